[hw/rtl/lsc_pkg.sv]
// Shared types and constants for the LRU signature cache.
// Depends on nothing; every other file of the block but lsc_ram imports it.
package lsc_pkg;

  localparam int KEY_W   = 64;
  localparam int STAMP_W = 64;
  localparam int TOT_W   = 32;
  localparam int CNT_W   = 6;

  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_INSERT = 1'b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic clr_wr;    // write an empty entry at the scan index, advance it
    logic load;      // capture the request, reset the scan trackers
    logic rd;        // read the entry at the scan index, advance it
    logic wr_hit;    // lookup writeback and hit/miss totals
    logic wr_evict;  // drop the victim if the cache is full
    logic wr_ins;    // store the new entry in the chosen slot
    logic out_load;  // move the finished item into the output register
  } lsc_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic idx_last;  // scan index sits on the last entry
    logic is_insert; // captured request is an insert
    logic out_free;  // output register can take a new item this cycle
  } lsc_sts_t;

endpackage

[hw/rtl/lsc_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module lsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/lsc_ctrl.sv]
// Sequencing state machine of the LRU signature cache.
// Depends on lsc_pkg; drives the datapath in lsc_dp through lsc_cmd_t.
module lsc_ctrl
  import lsc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  lsc_sts_t sts,
  output lsc_cmd_t ctl
);

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_SCAN  = 7'b0000100,
    ST_DRAIN = 7'b0001000,
    ST_UPD   = 7'b0010000,
    ST_INS   = 7'b0100000,
    ST_FIN   = 7'b1000000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    ctl        = '0;
    unique case (state)
      ST_CLEAR: begin
        ctl.clr_wr = 1'b1;
        if (sts.idx_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          ctl.load   = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        ctl.rd = 1'b1;
        if (sts.idx_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_next = ST_UPD;
      end
      ST_UPD: begin
        if (sts.is_insert) begin
          ctl.wr_evict = 1'b1;
          state_next   = ST_INS;
        end else begin
          ctl.wr_hit = 1'b1;
          state_next = ST_FIN;
        end
      end
      ST_INS: begin
        ctl.wr_ins = 1'b1;
        state_next = ST_FIN;
      end
      ST_FIN: begin
        if (sts.out_free) begin
          ctl.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

[hw/rtl/lsc_dp.sv]
// Datapath of the LRU signature cache: entry RAM, scan trackers, counters
// and output register. Depends on lsc_pkg and lsc_ram.
module lsc_dp
  import lsc_pkg::*;
#(
  parameter int CAPACITY     = 32,
  parameter int HANDLE_WIDTH = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  lsc_cmd_t                ctl,
  output lsc_sts_t                sts,
  input  logic                    cfg_wr,
  input  logic [CNT_W-1:0]        cfg_data,
  input  logic                    cmd,
  input  logic [KEY_W-1:0]        signature,
  input  logic [HANDLE_WIDTH-1:0] payload,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    hit,
  output logic [HANDLE_WIDTH-1:0] payload_out,
  output logic                    evicted,
  output logic [HANDLE_WIDTH-1:0] evicted_payload,
  output logic [CNT_W-1:0]        entry_count,
  output logic [TOT_W-1:0]        hit_count,
  output logic [TOT_W-1:0]        miss_count
);

  localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > CNT_W) ? CW : CNT_W;

  typedef struct packed {
    logic                    used;
    logic [KEY_W-1:0]        key;
    logic [HANDLE_WIDTH-1:0] hand;
    logic [STAMP_W-1:0]      use_st;
    logic [STAMP_W-1:0]      ins_st;
  } word_t;

  localparam int WORD_W = $bits(word_t);

  // request
  logic                    req_cmd;
  logic [KEY_W-1:0]        req_sig;
  logic [HANDLE_WIDTH-1:0] req_pay;

  // architectural state
  logic [CNT_W-1:0]   evict_limit;
  logic [CW-1:0]      count;
  logic [STAMP_W-1:0] stamp;
  logic [TOT_W-1:0]   hits;
  logic [TOT_W-1:0]   misses;

  // scan
  logic [AW-1:0] idx;
  logic          chk_vld;
  logic [AW-1:0] chk_idx;
  logic          idx_last;

  // trackers
  logic                    found;
  logic [AW-1:0]           best_idx;
  logic [HANDLE_WIDTH-1:0] best_hand;
  logic [STAMP_W-1:0]      best_ins;
  logic                    vic_found;
  logic [AW-1:0]           vic_idx;
  logic [HANDLE_WIDTH-1:0] vic_hand;
  logic [STAMP_W-1:0]      vic_use;
  logic                    free_found;
  logic [AW-1:0]           free_idx;
  logic                    ev_reg;

  // RAM
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  word_t             ram_wdata;
  logic [WORD_W-1:0] ram_rdata;
  word_t             rd_word;

  logic          is_lookup;
  logic          full;
  logic          evict_now;
  logic [AW-1:0] ins_slot;
  logic          ins_ok;
  logic          match_upd;
  logic          vic_upd;
  logic          free_upd;

  assign idx_last  = (idx == AW'(CAPACITY - 1));
  assign is_lookup = (req_cmd == CMD_LOOKUP);
  assign rd_word   = word_t'(ram_rdata);

  assign sts.idx_last  = idx_last;
  assign sts.is_insert = (req_cmd == CMD_INSERT);
  assign sts.out_free  = !out_valid || out_ready;

  // Limit is min(evict_limit, CAPACITY)
  assign full = (CMPW'(count) >= CMPW'(evict_limit)) || (count >= CW'(CAPACITY));
  assign evict_now = !is_lookup && (count != '0) && full && vic_found;

  // Freed victim slot competes with the lowest free slot seen
  always_comb begin
    ins_slot = free_idx;
    if (ev_reg && !(free_found && (free_idx < vic_idx))) ins_slot = vic_idx;
  end
  assign ins_ok = ev_reg || free_found;

  // Per-entry compare during the scan
  assign match_upd = chk_vld && rd_word.used && (rd_word.key == req_sig) &&
                     (!found || (rd_word.ins_st > best_ins));
  assign vic_upd   = chk_vld && rd_word.used && (!vic_found || (rd_word.use_st < vic_use));
  assign free_upd  = chk_vld && !rd_word.used && !free_found;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx;
    ram_wdata = '0;
    priority if (ctl.clr_wr) begin
      ram_we = 1'b1;
    end else if (ctl.wr_hit && found) begin
      ram_we           = 1'b1;
      ram_waddr        = best_idx;
      ram_wdata.used   = 1'b1;
      ram_wdata.key    = req_sig;
      ram_wdata.hand   = best_hand;
      ram_wdata.use_st = stamp;
      ram_wdata.ins_st = best_ins;
    end else if (ctl.wr_evict && evict_now) begin
      ram_we    = 1'b1;
      ram_waddr = vic_idx;
    end else if (ctl.wr_ins && ins_ok) begin
      ram_we           = 1'b1;
      ram_waddr        = ins_slot;
      ram_wdata.used   = 1'b1;
      ram_wdata.key    = req_sig;
      ram_wdata.hand   = req_pay;
      ram_wdata.use_st = stamp;
      ram_wdata.ins_st = stamp;
    end else begin
      ram_we = 1'b0;
    end
  end

  lsc_ram #(
    .WIDTH (WORD_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (WORD_W'(ram_wdata)),
    .re    (ctl.rd),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      idx         <= '0;
      chk_vld     <= 1'b0;
      evict_limit <= CNT_W'(32);
      count       <= '0;
      stamp       <= '0;
      hits        <= '0;
      misses      <= '0;
      found       <= 1'b0;
      vic_found   <= 1'b0;
      free_found  <= 1'b0;
      ev_reg      <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      chk_vld <= ctl.rd;
      if (ctl.clr_wr || ctl.rd) begin
        idx <= idx_last ? '0 : idx + AW'(1);
      end
      if (cfg_wr) evict_limit <= cfg_data;

      if (ctl.load) begin
        found      <= 1'b0;
        vic_found  <= 1'b0;
        free_found <= 1'b0;
        ev_reg     <= 1'b0;
      end else begin
        if (match_upd) found      <= 1'b1;
        if (vic_upd)   vic_found  <= 1'b1;
        if (free_upd)  free_found <= 1'b1;
      end

      if (ctl.wr_hit) begin
        if (found) begin
          stamp <= stamp + STAMP_W'(1);
          if (hits != '1) hits <= hits + TOT_W'(1);
        end else if (misses != '1) begin
          misses <= misses + TOT_W'(1);
        end
      end
      if (ctl.wr_evict && evict_now) begin
        ev_reg <= 1'b1;
        count  <= count - CW'(1);
      end
      if (ctl.wr_ins && ins_ok) begin
        stamp <= stamp + STAMP_W'(1);
        count <= count + CW'(1);
      end

      if (ctl.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      req_cmd <= cmd;
      req_sig <= signature;
      req_pay <= payload;
    end
    chk_idx <= idx;
    if (match_upd) begin
      best_idx  <= chk_idx;
      best_hand <= rd_word.hand;
      best_ins  <= rd_word.ins_st;
    end
    if (vic_upd) begin
      vic_idx  <= chk_idx;
      vic_hand <= rd_word.hand;
      vic_use  <= rd_word.use_st;
    end
    if (free_upd) free_idx <= chk_idx;
    if (ctl.out_load) begin
      hit             <= is_lookup && found;
      payload_out     <= (is_lookup && found) ? best_hand : '0;
      evicted         <= ev_reg;
      evicted_payload <= ev_reg ? vic_hand : '0;
      entry_count     <= CNT_W'(count);
      hit_count       <= hits;
      miss_count      <= misses;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    !(ram_we && ctl.rd))
    else $error("entry RAM written during a scan read");

  a_out_no_overrun: assert property (@(posedge clk) disable iff (rst)
    ctl.out_load |-> (!out_valid || out_ready))
    else $error("output register overwritten before it was taken");

  a_stamp_on_hit: assert property (@(posedge clk) disable iff (rst)
    (ctl.wr_hit && found) |=> (stamp == $past(stamp) + STAMP_W'(1)))
    else $error("stamp counter did not advance on a hit");

endmodule

[hw/rtl/lru_signature_cache.sv]
// LRU signature cache: lookup hits return the newest matching entry; inserts
// evict the least recently used entry once the limit is reached.
// Items are handled one at a time: a new item is accepted only once the last one
//   has moved into the output register; the scan of the entry RAM reads one entry
//   per cycle.
// Reset: synchronous; a clearing pass empties the RAM,
//   during which no item is accepted (configuration writes are).
module lru_signature_cache
  import lsc_pkg::*;
#(
  parameter int CAPACITY     = 32,
  parameter int HANDLE_WIDTH = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  // configuration: eviction limit
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CNT_W-1:0]        cfg_data,
  // request items
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    cmd,
  input  logic [KEY_W-1:0]        signature,
  input  logic [HANDLE_WIDTH-1:0] payload,
  // result items
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    hit,
  output logic [HANDLE_WIDTH-1:0] payload_out,
  output logic                    evicted,
  output logic [HANDLE_WIDTH-1:0] evicted_payload,
  output logic [CNT_W-1:0]        entry_count,
  output logic [TOT_W-1:0]        hit_count,
  output logic [TOT_W-1:0]        miss_count
);

  lsc_cmd_t ctl;
  lsc_sts_t sts;

  // The user must write the register only while idle; the block does not enforce it, so always take it.
  assign cfg_ready = 1'b1;

  // Controller: clearing pass, then load, scan, drain, writeback, deliver.
  lsc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  // Datapath: the scan reads one entry per cycle and tracks the newest match,
  // the least recently used entry and the lowest free slot at once; the
  // writeback then updates one entry (or stores anew, dropping the victim if full).
  lsc_dp #(
    .CAPACITY     (CAPACITY),
    .HANDLE_WIDTH (HANDLE_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .ctl             (ctl),
    .sts             (sts),
    .cfg_wr          (cfg_valid && cfg_ready),
    .cfg_data        (cfg_data),
    .cmd             (cmd),
    .signature       (signature),
    .payload         (payload),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .hit             (hit),
    .payload_out     (payload_out),
    .evicted         (evicted),
    .evicted_payload (evicted_payload),
    .entry_count     (entry_count),
    .hit_count       (hit_count),
    .miss_count      (miss_count)
  );

endmodule

[dv/tb_top.sv]
// Self-checking testbench for lru_signature_cache: lookups, inserts and LRU eviction
// against an in-bench cache predictor, with random idling on both item channels.
// Depends on lsc_pkg and the lru_signature_cache top level.
`timescale 1ns / 100ps

module tb_top;
  import lsc_pkg::*;

  localparam int SLOTS      = 32;
  localparam int HW         = 16;
  localparam int CYCLE_CAP  = 400000;
  localparam int POOL_DEPTH = 16;

  // One result item as the block reports it
  typedef struct packed {
    logic             hit;
    logic [HW-1:0]    payload_out;
    logic             evicted;
    logic [HW-1:0]    evicted_payload;
    logic [CNT_W-1:0] entry_count;
    logic [TOT_W-1:0] hit_count;
    logic [TOT_W-1:0] miss_count;
  } cache_reply_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CNT_W-1:0]   cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               cmd = CMD_LOOKUP;
  logic [KEY_W-1:0]   signature = '0;
  logic [HW-1:0]      payload = '0;
  logic               out_valid;
  logic               out_ready = 1'b1;
  logic               hit;
  logic [HW-1:0]      payload_out;
  logic               evicted;
  logic [HW-1:0]      evicted_payload;
  logic [CNT_W-1:0]   entry_count;
  logic [TOT_W-1:0]   hit_count;
  logic [TOT_W-1:0]   miss_count;

  lru_signature_cache #(
    .CAPACITY     (SLOTS),
    .HANDLE_WIDTH (HW)
  ) dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .cmd             (cmd),
    .signature       (signature),
    .payload         (payload),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .hit             (hit),
    .payload_out     (payload_out),
    .evicted         (evicted),
    .evicted_payload (evicted_payload),
    .entry_count     (entry_count),
    .hit_count       (hit_count),
    .miss_count      (miss_count)
  );

  always #2 clk = ~clk;

  // Predicted cache contents: only slots marked full are ever read
  bit               slot_full   [SLOTS];
  logic [KEY_W-1:0] slot_key    [SLOTS];
  logic [HW-1:0]    slot_handle [SLOTS];
  logic [63:0]      slot_used_at[SLOTS];
  logic [63:0]      slot_born_at[SLOTS];
  logic [CNT_W-1:0] fill_count   = '0;
  logic [63:0]      stamp_now    = '0;
  logic [TOT_W-1:0] hits_tally   = '0;
  logic [TOT_W-1:0] misses_tally = '0;
  logic [CNT_W-1:0] entry_limit  = 6'd32;

  cache_reply_t     replies_due[$];
  cache_reply_t     want;
  logic [KEY_W-1:0] key_pool[POOL_DEPTH];

  bit calm     = 1'b0;  // both sides run without idling while set
  int rx_hold  = 0;     // cycles the result side still holds off
  int failures = 0;
  int cycles   = 0;
  int n_lookups = 0, n_inserts = 0, n_hits = 0, n_evictions = 0, n_limits = 0;

  // Apply one item to the predicted cache and return the reply it should give.
  function automatic cache_reply_t apply_cache_op(logic c, logic [KEY_W-1:0] sig,
                                                  logic [HW-1:0] pay);
    cache_reply_t r;
    int           best;
    int           victim;
    int           slot;
    int           cap;
    r      = '0;
    best   = -1;
    victim = -1;
    slot   = -1;
    if (c == CMD_LOOKUP) begin
      // newest insertion wins among several matching entries
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_full[i] && slot_key[i] == sig) begin
          if (best < 0 || slot_born_at[i] > slot_born_at[best]) best = i;
        end
      end
      if (best >= 0) begin
        r.hit             = 1'b1;
        r.payload_out     = slot_handle[best];
        slot_used_at[best] = stamp_now;
        stamp_now++;
        if (hits_tally != '1) hits_tally++;
      end else begin
        if (misses_tally != '1) misses_tally++;
      end
    end else begin
      // a limit beyond the table size saturates to the table size
      cap = (entry_limit > SLOTS) ? SLOTS : int'(entry_limit);
      if (fill_count != 0 && int'(fill_count) >= cap) begin
        // oldest use goes first; the lowest slot takes a tie
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_full[i] && (victim < 0 || slot_used_at[i] < slot_used_at[victim])) victim = i;
        end
        if (victim >= 0) begin
          r.evicted         = 1'b1;
          r.evicted_payload = slot_handle[victim];
          slot_full[victim] = 1'b0;
          fill_count--;
        end
      end
      for (int i = 0; i < SLOTS; i++) begin
        if (!slot_full[i] && slot < 0) slot = i;
      end
      if (slot >= 0) begin
        slot_full[slot]    = 1'b1;
        slot_key[slot]     = sig;
        slot_handle[slot]  = pay;
        slot_used_at[slot] = stamp_now;
        slot_born_at[slot] = stamp_now;
        stamp_now++;
        fill_count++;
      end
    end
    r.entry_count = fill_count;
    r.hit_count   = hits_tally;
    r.miss_count  = misses_tally;
    return r;
  endfunction

  task automatic compare_field(string name, logic [63:0] exp_val, logic [63:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
      failures++;
    end
  endtask

  // Present one request item after a random gap; hold it until the block takes it.
  task automatic push_request(logic c, logic [KEY_W-1:0] sig, logic [HW-1:0] pay);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    cmd       <= c;
    signature <= sig;
    payload   <= pay;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    replies_due.push_back(apply_cache_op(c, sig, pay));
    if (c == CMD_INSERT) n_inserts++;
    else n_lookups++;
  endtask

  // Drop the request valid and hold until every predicted reply has arrived.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (replies_due.size() != 0);
  endtask

  // Write the eviction limit; callers but test_table_extremes drain the block first.
  task automatic set_entry_limit(logic [CNT_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    entry_limit = value;
    n_limits++;
    cfg_valid <= 1'b0;
  endtask

  // Result side: check each accepted item, then draw the stall before the next one.
  // The stall only counts down while a result is on offer, so it really back-pressures.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (replies_due.size() == 0) begin
        $error("result item with no request outstanding");
        failures++;
      end else begin
        want = replies_due.pop_front();
        compare_field("hit", 64'(want.hit), 64'(hit));
        compare_field("payload_out", 64'(want.payload_out), 64'(payload_out));
        compare_field("evicted", 64'(want.evicted), 64'(evicted));
        compare_field("evicted_payload", 64'(want.evicted_payload), 64'(evicted_payload));
        compare_field("entry_count", 64'(want.entry_count), 64'(entry_count));
        compare_field("hit_count", 64'(want.hit_count), 64'(hit_count));
        compare_field("miss_count", 64'(want.miss_count), 64'(miss_count));
        if (want.hit) n_hits++;
        if (want.evicted) n_evictions++;
      end
      rx_hold = calm ? 0 : $urandom_range(0, 3);
    end else if (out_valid && rx_hold != 0) begin
      rx_hold--;
    end
    out_ready <= (rx_hold == 0);
  end

  // Watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_CAP) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Extreme keys and handles: all-zero and all-one keys, handle zero and handle all-ones,
  // a lookup on an empty table and a near-miss key.
  task automatic test_table_extremes();
    set_entry_limit(6'd32);
    push_request(CMD_LOOKUP, '0, '1);
    push_request(CMD_INSERT, '0, '0);
    push_request(CMD_LOOKUP, '0, '0);
    push_request(CMD_INSERT, '1, '1);
    push_request(CMD_LOOKUP, '1, '0);
    push_request(CMD_LOOKUP, 64'h1, 16'h5A5A);
  endtask

  // Same key stored several times: the most recent insertion must answer.
  task automatic test_newest_duplicate();
    logic [KEY_W-1:0] k;
    k = {$urandom, $urandom};
    push_request(CMD_INSERT, k, 16'h1111);
    push_request(CMD_INSERT, k, 16'h2222);
    push_request(CMD_LOOKUP, k, '0);
    push_request(CMD_INSERT, k, 16'h3333);
    push_request(CMD_LOOKUP, k, '0);
  endtask

  // Table over the limit: a lookup bumps one entry, so the next inserts evict others.
  task automatic test_lru_eviction();
    logic [KEY_W-1:0] k;
    k = {$urandom, $urandom};
    wait_drained();
    set_entry_limit(6'd2);
    push_request(CMD_LOOKUP, '0, '0);
    push_request(CMD_INSERT, k, 16'hC0DE);
    push_request(CMD_INSERT, {$urandom, $urandom}, 16'h00F0);
    push_request(CMD_LOOKUP, k, '0);
  endtask

  // Limit zero: every insert into a non-empty table evicts.
  task automatic test_zero_limit();
    logic [KEY_W-1:0] ka;
    logic [KEY_W-1:0] kb;
    ka = {$urandom, $urandom};
    kb = {$urandom, $urandom};
    wait_drained();
    set_entry_limit(6'd0);
    push_request(CMD_INSERT, ka, 16'hAAAA);
    push_request(CMD_INSERT, kb, 16'h5555);
    push_request(CMD_LOOKUP, ka, '0);
    push_request(CMD_LOOKUP, kb, '0);
  endtask

  // Limit beyond the table size: the block must treat it as full capacity.
  task automatic test_limit_saturation();
    logic [KEY_W-1:0] k;
    k = {$urandom, $urandom};
    wait_drained();
    set_entry_limit(6'd63);
    push_request(CMD_INSERT, k, 16'h8001);
    push_request(CMD_INSERT, {$urandom, $urandom}, 16'h7FFE);
    push_request(CMD_LOOKUP, k, '0);
  endtask

  // Phases of mixed traffic over a small key pool so lookups hit and the table
  // fills; each phase picks a fresh limit, some phases run without idling.
  task automatic test_random_traffic(int n_items);
    int               sent;
    int               span;
    int               ins_pct;
    logic [KEY_W-1:0] k;
    logic [CNT_W-1:0] lim;
    logic             c;
    sent = 0;
    while (sent < n_items) begin
      wait_drained();
      case ($urandom_range(0, 5))
        0:       lim = 6'd0;
        1:       lim = 6'($urandom_range(1, 4));
        2:       lim = 6'($urandom_range(5, 12));
        3:       lim = 6'd32;
        4:       lim = 6'($urandom_range(33, 63));
        default: lim = 6'($urandom_range(0, 63));
      endcase
      set_entry_limit(lim);
      calm    = ($urandom_range(0, 3) == 0);
      ins_pct = (lim >= 6'd32) ? 65 : 45;
      for (int i = 0; i < POOL_DEPTH; i++) key_pool[i] = {$urandom, $urandom};
      if ($urandom_range(0, 1)) key_pool[0] = '0;
      if ($urandom_range(0, 1)) key_pool[1] = '1;
      span = $urandom_range(40, 100);
      for (int j = 0; j < span && sent < n_items; j++) begin
        c = ($urandom_range(1, 100) <= ins_pct) ? CMD_INSERT : CMD_LOOKUP;
        if ($urandom_range(1, 100) <= 75) k = key_pool[$urandom_range(0, POOL_DEPTH - 1)];
        else k = {$urandom, $urandom};
        // churn the pool so fresh keys become lookup targets
        if (c == CMD_INSERT && $urandom_range(0, 3) == 0)
          key_pool[$urandom_range(0, POOL_DEPTH - 1)] = k;
        push_request(c, k, 16'($urandom));
        sent++;
        // now and then hold the sender until the block has fully drained
        if ($urandom_range(0, 63) == 0) wait_drained();
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_table_extremes();
    test_newest_duplicate();
    test_lru_eviction();
    test_zero_limit();
    test_limit_saturation();
    test_random_traffic(850);

    // Drain, then give a stray result time to show up
    wait_drained();
    repeat (2 * SLOTS + 8) @(posedge clk);
    if (replies_due.size() != 0) begin
      $error("%0d result items never arrived", replies_due.size());
      failures++;
    end

    $display("Ran %0d lookups and %0d inserts over %0d limit settings.",
             n_lookups, n_inserts, n_limits);
    $display("Saw %0d hits and %0d evictions; %0d mismatches.",
             n_hits, n_evictions, failures);
    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
